// ===== design/assert_macros.svh =====
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define W3BS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds whenever the antecedent does
`define W3BS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/w3bs_pkg.sv =====
// shared types and constants of the 3x3 window filter
`timescale 1ns / 1ps
package w3bs_pkg;
	localparam int MAX_SIDE_DEF = 1024;
	localparam int CFG_W = 11;
	localparam int SIDE_RESET = 3;
	localparam int MIN_SIDE = 3;
	localparam int PIX_W = 24;
	localparam int RECIP9 = 3641;
	localparam int SHIFT9 = 15;
	localparam int RECIP7 = 2341;
	localparam int SHIFT7 = 14;

	typedef logic [7:0] chan_t;
	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [8:0][PIX_W-1:0] win_t;
	typedef logic [8:0][7:0] win_ch_t;

	typedef enum logic [1:0] {
		MODE_BOX = 2'd0,
		MODE_TRIM = 2'd1,
		MODE_SHARP = 2'd2
	} mode_t;

	typedef enum logic {
		CFG_SIDE = 1'b0,
		CFG_MODE = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic load_s4;
		logic load_s5;
		logic interior;
		logic [1:0] mode;
	} lane_ctl_t;
endpackage

// ===== design/w3bs_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module w3bs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== design/w3bs_ext.sv =====
// darkest and brightest pixel search over the 3x3 window
`timescale 1ns / 1ps
module w3bs_ext (
	input  w3bs_pkg::win_t win,
	output logic [3:0]     lo,
	output logic [3:0]     hi
);
	always_comb begin
		logic [9:0] s;
		logic [9:0] vmin;
		logic [9:0] vmax;
		vmin = 10'(win[0][7:0]) + 10'(win[0][15:8]) + 10'(win[0][23:16]);
		vmax = vmin;
		lo = 4'd0;
		hi = 4'd0;
		for (int i = 1; i < 9; i++) begin
			s = 10'(win[i][7:0]) + 10'(win[i][15:8]) + 10'(win[i][23:16]);
			if (s <= vmin) begin
				vmin = s;
				lo = 4'(i);
			end else if (s > vmax) begin
				vmax = s;
				hi = 4'(i);
			end
		end
	end
endmodule

// ===== design/w3bs_lane.sv =====
// one color channel lane: window sums, reciprocal divide, sharpen and clamp
`timescale 1ns / 1ps
module w3bs_lane (
	input  logic                  clk,
	input  w3bs_pkg::lane_ctl_t   ctl,
	input  w3bs_pkg::win_ch_t     ch,
	input  logic [3:0]            lo,
	input  logic [3:0]            hi,
	output w3bs_pkg::chan_t       res
);
	typedef enum logic [1:0] {OP_PASS, OP_DIV9, OP_DIV7, OP_SHARP} op_t;

	op_t                op, op_s4;
	logic [11:0]        sum9, trim, num, num_s4, c10;
	logic signed [12:0] sharp, sharp_s4;
	logic [7:0]         cen_s4, res_n;
	logic [11:0]        recip;
	logic [23:0]        prod;

	always_comb begin
		sum9 = '0;
		for (int i = 0; i < 9; i++) begin
			sum9 = sum9 + 12'(ch[i]);
		end
		trim = sum9 - 12'(ch[lo]) - 12'(ch[hi]);
		c10 = {1'b0, ch[4], 3'b000} + {3'b000, ch[4], 1'b0};
		sharp = $signed({1'b0, c10}) - $signed({1'b0, sum9});
		if (!ctl.interior) begin
			op = OP_PASS;
		end else begin
			case (w3bs_pkg::mode_t'(ctl.mode))
				w3bs_pkg::MODE_TRIM:  op = OP_DIV7;
				w3bs_pkg::MODE_SHARP: op = OP_SHARP;
				default:              op = OP_DIV9;
			endcase
		end
		num = (op == OP_DIV7) ? trim : sum9;
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s4) begin
			op_s4 <= op;
			num_s4 <= num;
			sharp_s4 <= sharp;
			cen_s4 <= ch[4];
		end
		if (ctl.load_s5) begin
			res <= res_n;
		end
	end

	always_comb begin
		recip = (op_s4 == OP_DIV7) ? 12'(w3bs_pkg::RECIP7) : 12'(w3bs_pkg::RECIP9);
		prod = 24'(num_s4) * 24'(recip);
		case (op_s4)
			OP_PASS:  res_n = cen_s4;
			OP_DIV7:  res_n = prod[w3bs_pkg::SHIFT7+7:w3bs_pkg::SHIFT7];
			OP_SHARP: begin
				if (sharp_s4 < 0) begin
					res_n = 8'd0;
				end else if (sharp_s4 > 13'sd255) begin
					res_n = 8'd255;
				end else begin
					res_n = sharp_s4[7:0];
				end
			end
			default:  res_n = prod[w3bs_pkg::SHIFT9+7:w3bs_pkg::SHIFT9];
		endcase
	end
endmodule

// ===== design/window3x3_blur_sharpen_filter_unit.sv =====
// top level of the 3x3 blur and sharpen filter with line stores and channel lanes
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Takes one raster pixel per clock and returns at most one filtered pixel per clock,
// sustained at one item per cycle, held only by out_stall. Each accepted pixel runs
// through five register stages: line store read, window shift, min/max search, lane
// sums, and reciprocal divide with clamp into the output register. The result for a
// pixel leaves side + 1 items after it, so side + 1 filler items must follow a frame;
// frame_last marks its final result. Line stores need no clearing after reset.
// Writing image_side aborts the frame in progress; configure only while idle.
module window3x3_blur_sharpen_filter_unit #(
	parameter int MAX_SIDE = w3bs_pkg::MAX_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic        is_filler,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        frame_last
);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int COL_W = $clog2(MAX_SIDE);
	localparam int ROW_W = $clog2(MAX_SIDE + 2);
	localparam int PEND_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int CMP_W = (SIDE_W > w3bs_pkg::CFG_W) ? SIDE_W : w3bs_pkg::CFG_W;

	logic [10:0]       image_side_q;
	logic [1:0]        filter_mode_q;
	logic [ROW_W-1:0]  row_q, row_n;
	logic [COL_W-1:0]  col_q, col_n;
	logic [PEND_W-1:0] pend_q, pend_base, pend_n, sq;
	logic [SIDE_W-1:0] side, col_inc;
	logic [CMP_W-1:0]  side_raw;
	logic              row_lt, ignore, take, enter, emit, interior, last, wrap;
	logic              cfg_we;
	w3bs_pkg::pix_t    pix, up_rd, mid_rd;

	logic              v1, v2, v3, v4, v5;
	logic              ready1, ready2, ready3, ready4, ready5;
	w3bs_pkg::pix_t    pix_s1;
	logic [COL_W-1:0]  col_s1;
	logic              emit_s1, int_s1, last_s1;
	w3bs_pkg::win_t    window_q, win_s3;
	logic              emit_s2, int_s2, last_s2;
	logic [3:0]        lo, hi, lo_s3, hi_s3;
	logic              int_s3, last_s3, last_s4, last_s5;
	w3bs_pkg::lane_ctl_t ctl;
	logic [2:0][8:0][7:0] lane_ch;
	logic [2:0][7:0]   lane_res;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;

	// effective side and frame position bookkeeping
	always_comb begin
		side_raw = CMP_W'(image_side_q);
		if (side_raw < CMP_W'(w3bs_pkg::MIN_SIDE)) begin
			side = SIDE_W'(w3bs_pkg::MIN_SIDE);
		end else if (side_raw > CMP_W'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = side_raw[SIDE_W-1:0];
		end
		sq = PEND_W'(side) * PEND_W'(side);
		row_lt = row_q < ROW_W'(side);
		ignore = is_filler && row_lt;
		pix = row_lt ? {blue_in, green_in, red_in} : '0;
		pend_base = (row_q == '0 && col_q == '0) ? sq : pend_q;
		emit = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		interior = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2)) && row_lt;
		col_inc = SIDE_W'(col_q) + SIDE_W'(1);
		wrap = col_inc == side;
		col_n = wrap ? '0 : col_inc[COL_W-1:0];
		row_n = wrap ? row_q + ROW_W'(1) : row_q;
		pend_n = (emit && pend_base != '0) ? pend_base - PEND_W'(1) : pend_base;
		last = emit && (pend_n == '0);
	end

	// pipeline flow
	assign ready5 = !v5 || !out_stall;
	assign ready4 = !v4 || ready5;
	assign ready3 = !v3 || ready4;
	assign ready2 = !v2 || ready3;
	assign ready1 = !v1 || ready2;
	assign in_stall = !ready1;
	assign take = in_valid && ready1;
	assign enter = take && !ignore;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_side_q <= 11'(w3bs_pkg::SIDE_RESET);
			filter_mode_q <= w3bs_pkg::MODE_BOX;
			row_q <= '0;
			col_q <= '0;
			pend_q <= '0;
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == w3bs_pkg::CFG_SIDE) begin
				image_side_q <= cfg_data;
				row_q <= '0;
				col_q <= '0;
				pend_q <= '0;
			end else if (enter) begin
				row_q <= last ? '0 : row_n;
				col_q <= last ? '0 : col_n;
				pend_q <= pend_n;
			end
			if (cfg_we && cfg_index == w3bs_pkg::CFG_MODE) begin
				filter_mode_q <= cfg_data[1:0];
			end
			if (ready1) v1 <= enter;
			if (ready2) v2 <= v1;
			if (ready3) v3 <= v2 && emit_s2;
			if (ready4) v4 <= v3;
			if (ready5) v5 <= v4;
		end
	end

	w3bs_ram #(.WIDTH(w3bs_pkg::PIX_W), .DEPTH(MAX_SIDE)) u_upper (
		.clk(clk), .we(v1 && ready2), .waddr(col_s1), .wdata(mid_rd),
		.re(enter), .raddr(col_q), .rdata(up_rd)
	);

	w3bs_ram #(.WIDTH(w3bs_pkg::PIX_W), .DEPTH(MAX_SIDE)) u_middle (
		.clk(clk), .we(v1 && ready2), .waddr(col_s1), .wdata(pix_s1),
		.re(enter), .raddr(col_q), .rdata(mid_rd)
	);

	w3bs_ext u_ext (.win(window_q), .lo(lo), .hi(hi));

	always_ff @(posedge clk) begin
		if (ready1 && enter) begin
			pix_s1 <= pix;
			col_s1 <= col_q;
			emit_s1 <= emit;
			int_s1 <= interior;
			last_s1 <= last;
		end
		if (ready2 && v1) begin
			window_q <= {pix_s1, window_q[8], window_q[7], mid_rd, window_q[5],
				window_q[4], up_rd, window_q[2], window_q[1]};
			emit_s2 <= emit_s1;
			int_s2 <= int_s1;
			last_s2 <= last_s1;
		end
		if (ready3 && v2) begin
			win_s3 <= window_q;
			lo_s3 <= lo;
			hi_s3 <= hi;
			int_s3 <= int_s2;
			last_s3 <= last_s2;
		end
		if (ready4 && v3) begin
			last_s4 <= last_s3;
		end
		if (ready5 && v4) begin
			last_s5 <= last_s4;
		end
	end

	// channel lanes and merge
	assign ctl.load_s4 = ready4 && v3;
	assign ctl.load_s5 = ready5 && v4;
	assign ctl.interior = int_s3;
	assign ctl.mode = filter_mode_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 9; i++) begin
				lane_ch[k][i] = win_s3[i][8*k +: 8];
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		w3bs_lane u_lane (
			.clk(clk), .ctl(ctl), .ch(lane_ch[k]), .lo(lo_s3), .hi(hi_s3),
			.res(lane_res[k])
		);
	end

	assign out_valid = v5;
	assign red_out = lane_res[0];
	assign green_out = lane_res[1];
	assign blue_out = lane_res[2];
	assign frame_last = last_s5;

	`W3BS_ASSERT(a_col_range, SIDE_W'(col_q) < side, "column position beyond frame side")
	`W3BS_ASSERT(a_row_range, row_q <= ROW_W'(side) + ROW_W'(1), "row beyond drain rows")
	`W3BS_ASSERT_IMPL(a_ext_distinct, v3 && int_s3, lo_s3 != hi_s3, "min and max pixel coincide")
endmodule
